// ----- rtl/core/hosl_pkg.sv -----
package hosl_pkg;

    localparam int TIME_W     = 48;
    localparam int TEMP_W     = 16;
    localparam int WATTS_W    = 16;
    localparam int MS_W       = 22;
    localparam int CFG_DATA_W = 22;
    localparam int CFG_IDX_W  = 3;

    localparam logic                      RST_OVERRIDE_EN  = 1'b1;
    localparam logic                      RST_POWER_MON_EN = 1'b1;
    localparam logic signed [TEMP_W-1:0]  RST_TEMP_MAX     = 16'sd820;
    localparam logic        [WATTS_W-1:0] RST_WATTS_THR    = 16'd5;
    localparam logic                      RST_PLUG_CFG     = 1'b0;
    localparam logic        [MS_W-1:0]    RST_GRACE_MS     = 22'd90000;
    localparam logic        [MS_W-1:0]    RST_RETRY_MS     = 22'd30000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERRIDE_EN  = 3'd0,
        CFG_POWER_MON_EN = 3'd1,
        CFG_TEMP_MAX     = 3'd2,
        CFG_WATTS_THR    = 3'd3,
        CFG_PLUG_CFG     = 3'd4,
        CFG_GRACE_MS     = 3'd5,
        CFG_RETRY_MS     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REASON_NONE = 2'd0,
        REASON_TEMP = 2'd1,
        REASON_PLUG = 2'd2
    } t_reason;

    typedef enum logic {
        REQ_MONITOR = 1'b0,
        REQ_GRACE   = 1'b1
    } t_req;

    typedef struct packed {
        logic                      overtemp_alarm_en;
        logic                      power_monitor_enabled;
        logic signed [TEMP_W-1:0]  temp_max;
        logic        [WATTS_W-1:0] watts_threshold;
        logic                      plug_configured;
        logic        [MS_W-1:0]    grace_ms;
        logic        [MS_W-1:0]    retry_ms;
    } t_cfg;

    typedef struct packed {
        t_req                      req_type;
        logic        [TIME_W-1:0]  now_ms;
        logic                      maintenance_busy;
        logic                      calibration_active;
        logic                      link_up;
        logic                      heater_off;
        logic                      heater_reading_valid;
        logic signed [TEMP_W-1:0]  temperature;
        logic        [WATTS_W-1:0] heater_watts;
        logic                      plug_watts_ok;
        logic        [WATTS_W-1:0] plug_watts;
        logic                      plug_relay_on;
    } t_item;

    typedef struct packed {
        logic    alarm_active;
        t_reason alarm_reason;
        logic    alarm_latched;
        logic    plug_off_command;
    } t_result;

endpackage

// ----- rtl/core/heater_overtemp_safety_latch_unit.sv -----
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   request, time, status flags, readings
// out       output     o_out_valid / i_out_stall alarm_active, alarm_reason, latched, plug_off
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One transaction per cycle sustained while the result is not stalled.
// The input register feeds the decision logic, whose state updates as the
// transaction moves into the result register.
// Synchronous active-low reset clears state and loads register defaults.
// A stalled result holds; the input stalls only while both stages are full and
// the result is stalled.
module heater_overtemp_safety_latch_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_we,
    input  logic [hosl_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [hosl_pkg::CFG_DATA_W-1:0]       i_cfg_data,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_req_type,
    input  logic [hosl_pkg::TIME_W-1:0]           i_now_ms,
    input  logic                                  i_maintenance_busy,
    input  logic                                  i_calibration_active,
    input  logic                                  i_link_up,
    input  logic                                  i_heater_off,
    input  logic                                  i_heater_reading_valid,
    input  logic signed [hosl_pkg::TEMP_W-1:0]    i_temperature,
    input  logic [hosl_pkg::WATTS_W-1:0]          i_heater_watts,
    input  logic                                  i_plug_watts_ok,
    input  logic [hosl_pkg::WATTS_W-1:0]          i_plug_watts,
    input  logic                                  i_plug_relay_on,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_alarm_active,
    output logic [1:0]                            o_alarm_reason,
    output logic                                  o_alarm_latched,
    output logic                                  o_plug_off_command
);

    hosl_pkg::t_cfg    r_cfg;
    hosl_pkg::t_item   r_s1_item;
    logic              r_s1_valid;
    hosl_pkg::t_result r_out;
    logic              r_out_valid;
    hosl_pkg::t_result w_result;
    logic              w_adv;
    logic              w_accept;

    assign w_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overtemp_alarm_en     <= hosl_pkg::RST_OVERRIDE_EN;
            r_cfg.power_monitor_enabled <= hosl_pkg::RST_POWER_MON_EN;
            r_cfg.temp_max              <= hosl_pkg::RST_TEMP_MAX;
            r_cfg.watts_threshold       <= hosl_pkg::RST_WATTS_THR;
            r_cfg.plug_configured       <= hosl_pkg::RST_PLUG_CFG;
            r_cfg.grace_ms              <= hosl_pkg::RST_GRACE_MS;
            r_cfg.retry_ms              <= hosl_pkg::RST_RETRY_MS;
        end else if (i_cfg_we) begin
            unique case (hosl_pkg::t_cfg_idx'(i_cfg_idx))
                hosl_pkg::CFG_OVERRIDE_EN:  r_cfg.overtemp_alarm_en     <= i_cfg_data[0];
                hosl_pkg::CFG_POWER_MON_EN: r_cfg.power_monitor_enabled <= i_cfg_data[0];
                hosl_pkg::CFG_TEMP_MAX:
                    r_cfg.temp_max <= $signed(i_cfg_data[hosl_pkg::TEMP_W-1:0]);
                hosl_pkg::CFG_WATTS_THR:
                    r_cfg.watts_threshold <= i_cfg_data[hosl_pkg::WATTS_W-1:0];
                hosl_pkg::CFG_PLUG_CFG:     r_cfg.plug_configured       <= i_cfg_data[0];
                hosl_pkg::CFG_GRACE_MS:
                    r_cfg.grace_ms <= i_cfg_data[hosl_pkg::MS_W-1:0];
                hosl_pkg::CFG_RETRY_MS:
                    r_cfg.retry_ms <= i_cfg_data[hosl_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_item.req_type             <= hosl_pkg::t_req'(i_req_type);
            r_s1_item.now_ms               <= i_now_ms;
            r_s1_item.maintenance_busy     <= i_maintenance_busy;
            r_s1_item.calibration_active   <= i_calibration_active;
            r_s1_item.link_up              <= i_link_up;
            r_s1_item.heater_off           <= i_heater_off;
            r_s1_item.heater_reading_valid <= i_heater_reading_valid;
            r_s1_item.temperature          <= i_temperature;
            r_s1_item.heater_watts         <= i_heater_watts;
            r_s1_item.plug_watts_ok        <= i_plug_watts_ok;
            r_s1_item.plug_watts           <= i_plug_watts;
            r_s1_item.plug_relay_on        <= i_plug_relay_on;
        end
    end

    hosl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_item   (r_s1_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_alarm_active     = r_out.alarm_active;
    assign o_alarm_reason     = r_out.alarm_reason;
    assign o_alarm_latched    = r_out.alarm_latched;
    assign o_plug_off_command = r_out.plug_off_command;

    a_latched_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.alarm_latched |-> r_out.alarm_active)
        else $error("latched alarm without a shown reason");

    a_reason_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.alarm_active == (r_out.alarm_reason != hosl_pkg::REASON_NONE))
                        && (r_out.alarm_reason != 2'd3))
        else $error("alarm reason and active flag disagree");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_adv |=> r_s1_valid)
        else $error("input stage lost a transaction");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced transaction missing from result stage");

endmodule

// ----- rtl/core/hosl_core.sv -----
module hosl_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  hosl_pkg::t_item  i_item,
    input  hosl_pkg::t_cfg   i_cfg,
    output hosl_pkg::t_result o_result
);

    localparam int TIME_W = hosl_pkg::TIME_W;
    localparam int MS_W   = hosl_pkg::MS_W;

    hosl_pkg::t_reason   r_latched, n_latched;
    hosl_pkg::t_reason   r_shown, n_shown;
    logic [TIME_W-1:0]   r_grace_until, n_grace_until;
    logic                r_grace_set, n_grace_set;
    logic [TIME_W-1:0]   r_last_off, n_last_off;
    logic                r_attempt_set, n_attempt_set;

    logic                plug_valid;
    logic                mismatch;
    logic                temp_alarm;
    logic                in_grace;
    logic                relay_on;
    logic                restored;
    logic                should_off;
    logic                too_soon;
    logic                cmd;
    logic [TIME_W-1:0]   elapsed;
    hosl_pkg::t_reason   instant;
    hosl_pkg::t_reason   lat_set;

    always_comb begin
        plug_valid = !i_item.calibration_active && i_item.plug_watts_ok && i_item.heater_off
                     && i_cfg.plug_configured && i_item.link_up;
        mismatch   = plug_valid && (i_item.plug_watts > i_cfg.watts_threshold);
        temp_alarm = i_cfg.overtemp_alarm_en && i_item.heater_reading_valid
                     && (i_item.temperature > i_cfg.temp_max)
                     && (i_item.heater_watts > i_cfg.watts_threshold);
        in_grace   = r_grace_set && (i_item.now_ms < r_grace_until);

        if (temp_alarm) begin
            instant = hosl_pkg::REASON_TEMP;
        end else if (!in_grace && i_cfg.power_monitor_enabled && mismatch) begin
            instant = hosl_pkg::REASON_PLUG;
        end else begin
            instant = hosl_pkg::REASON_NONE;
        end

        lat_set = (r_latched == hosl_pkg::REASON_NONE) ? instant : r_latched;

        relay_on = i_cfg.plug_configured ? (i_item.link_up && i_item.plug_relay_on) : 1'b1;
        restored = relay_on && !temp_alarm && !(i_item.heater_off && mismatch);

        should_off = temp_alarm || (!in_grace && mismatch
                     && (i_cfg.overtemp_alarm_en || i_cfg.power_monitor_enabled));
        elapsed    = i_item.now_ms - r_last_off;
        too_soon   = r_attempt_set
                     && (elapsed < {{(TIME_W-MS_W){1'b0}}, i_cfg.retry_ms});

        n_latched     = r_latched;
        n_shown       = r_shown;
        n_grace_until = r_grace_until;
        n_grace_set   = r_grace_set;
        n_last_off    = r_last_off;
        n_attempt_set = r_attempt_set;
        cmd           = 1'b0;

        if (i_item.req_type == hosl_pkg::REQ_GRACE) begin
            n_grace_until = i_item.now_ms + {{(TIME_W-MS_W){1'b0}}, i_cfg.grace_ms};
            n_grace_set   = 1'b1;
            n_attempt_set = 1'b0;
            n_last_off    = '0;
        end else if (i_item.maintenance_busy) begin
            n_latched     = hosl_pkg::REASON_NONE;
            n_shown       = hosl_pkg::REASON_NONE;
            n_attempt_set = 1'b0;
            n_last_off    = '0;
            n_grace_set   = 1'b0;
            n_grace_until = '0;
        end else begin
            n_latched = (lat_set != hosl_pkg::REASON_NONE && restored)
                        ? hosl_pkg::REASON_NONE : lat_set;
            n_shown   = (n_latched != hosl_pkg::REASON_NONE) ? n_latched : instant;
            if (should_off) begin
                if (!i_item.calibration_active && !too_soon && i_item.link_up) begin
                    n_last_off    = i_item.now_ms;
                    n_attempt_set = 1'b1;
                    cmd           = 1'b1;
                end
            end else if (instant == hosl_pkg::REASON_NONE) begin
                n_attempt_set = 1'b0;
                n_last_off    = '0;
            end
        end

        o_result.alarm_active     = (n_shown != hosl_pkg::REASON_NONE);
        o_result.alarm_reason     = n_shown;
        o_result.alarm_latched    = (n_latched != hosl_pkg::REASON_NONE);
        o_result.plug_off_command = cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched     <= hosl_pkg::REASON_NONE;
            r_shown       <= hosl_pkg::REASON_NONE;
            r_grace_until <= '0;
            r_grace_set   <= 1'b0;
            r_last_off    <= '0;
            r_attempt_set <= 1'b0;
        end else if (i_fire) begin
            r_latched     <= n_latched;
            r_shown       <= n_shown;
            r_grace_until <= n_grace_until;
            r_grace_set   <= n_grace_set;
            r_last_off    <= n_last_off;
            r_attempt_set <= n_attempt_set;
        end
    end

endmodule

// ----- dv/heater_overtemp_safety_latch_unit_tb.sv -----
`timescale 1ns / 1ps

module heater_overtemp_safety_latch_unit_tb;

    localparam int DRAIN_CYCLES    = 4;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 86;
    localparam int MAX_MS          = 3600000;
    localparam int MAX_PRINTS      = 40;
    localparam int TIME_W          = hosl_pkg::TIME_W;
    localparam int CFG_DATA_W      = hosl_pkg::CFG_DATA_W;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    hosl_pkg::t_cfg_idx    cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    hosl_pkg::t_item       drv_item;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  alarm_active;
    logic [1:0]            alarm_reason;
    logic                  alarm_latched;
    logic                  plug_off_command;

    // predictor state and register mirror
    hosl_pkg::t_cfg        active_cfg;
    hosl_pkg::t_reason     held_reason   = hosl_pkg::REASON_NONE;
    hosl_pkg::t_reason     shown_reason  = hosl_pkg::REASON_NONE;
    logic [TIME_W-1:0]     grace_until   = '0;
    logic                  grace_armed   = 1'b0;
    logic [TIME_W-1:0]     last_attempt_ms = '0;
    logic                  attempt_armed = 1'b0;

    hosl_pkg::t_result     expected_alarms[$];
    int                    mismatch_count = 0;

    int                    stall_mode = 0;
    int                    stall_left = 0;
    int                    stall_tick = 0;

    heater_overtemp_safety_latch_unit DUT (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_idx              (cfg_idx),
        .i_cfg_data             (cfg_data),
        .i_in_valid             (in_valid),
        .o_in_stall             (in_stall),
        .i_req_type             (drv_item.req_type),
        .i_now_ms               (drv_item.now_ms),
        .i_maintenance_busy     (drv_item.maintenance_busy),
        .i_calibration_active   (drv_item.calibration_active),
        .i_link_up              (drv_item.link_up),
        .i_heater_off           (drv_item.heater_off),
        .i_heater_reading_valid (drv_item.heater_reading_valid),
        .i_temperature          (drv_item.temperature),
        .i_heater_watts         (drv_item.heater_watts),
        .i_plug_watts_ok        (drv_item.plug_watts_ok),
        .i_plug_watts           (drv_item.plug_watts),
        .i_plug_relay_on        (drv_item.plug_relay_on),
        .o_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .o_alarm_active         (alarm_active),
        .o_alarm_reason         (alarm_reason),
        .o_alarm_latched        (alarm_latched),
        .o_plug_off_command     (plug_off_command)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic hosl_pkg::t_result predict_alarm(hosl_pkg::t_item it);
        hosl_pkg::t_result res;
        hosl_pkg::t_reason instant;
        logic              plug_valid, mismatch, temp_alarm, in_grace, should_off;
        logic              too_soon, relay_on, restored;
        logic [TIME_W-1:0] elapsed;
        res = '0;
        if (it.req_type == hosl_pkg::REQ_GRACE) begin
            grace_until     = it.now_ms + {26'd0, active_cfg.grace_ms};
            grace_armed     = 1'b1;
            attempt_armed   = 1'b0;
            last_attempt_ms = '0;
        end else if (it.maintenance_busy) begin
            held_reason     = hosl_pkg::REASON_NONE;
            shown_reason    = hosl_pkg::REASON_NONE;
            attempt_armed   = 1'b0;
            last_attempt_ms = '0;
            grace_armed     = 1'b0;
            grace_until     = '0;
        end else begin
            plug_valid = !it.calibration_active && it.plug_watts_ok && it.heater_off &&
                         active_cfg.plug_configured && it.link_up;
            mismatch   = plug_valid && (it.plug_watts > active_cfg.watts_threshold);
            temp_alarm = active_cfg.overtemp_alarm_en && it.heater_reading_valid &&
                         ($signed(it.temperature) > $signed(active_cfg.temp_max)) &&
                         (it.heater_watts > active_cfg.watts_threshold);
            in_grace   = grace_armed && (it.now_ms < grace_until);
            instant    = hosl_pkg::REASON_NONE;
            if (temp_alarm) begin
                instant = hosl_pkg::REASON_TEMP;
            end else if (!in_grace && active_cfg.power_monitor_enabled && mismatch) begin
                instant = hosl_pkg::REASON_PLUG;
            end
            if (instant != hosl_pkg::REASON_NONE && held_reason == hosl_pkg::REASON_NONE) begin
                held_reason = instant;
            end
            if (held_reason != hosl_pkg::REASON_NONE) begin
                relay_on = active_cfg.plug_configured ? (it.link_up && it.plug_relay_on) : 1'b1;
                restored = relay_on && !temp_alarm && !(it.heater_off && mismatch);
                if (restored) begin
                    held_reason = hosl_pkg::REASON_NONE;
                end
            end
            shown_reason = (held_reason != hosl_pkg::REASON_NONE) ? held_reason : instant;
            should_off = temp_alarm || (!in_grace && mismatch &&
                         (active_cfg.overtemp_alarm_en || active_cfg.power_monitor_enabled));
            if (should_off) begin
                if (!it.calibration_active) begin
                    elapsed  = it.now_ms - last_attempt_ms;
                    too_soon = attempt_armed && (elapsed < {26'd0, active_cfg.retry_ms});
                    if (!too_soon && it.link_up) begin
                        last_attempt_ms      = it.now_ms;
                        attempt_armed        = 1'b1;
                        res.plug_off_command = 1'b1;
                    end
                end
            end else if (instant == hosl_pkg::REASON_NONE) begin
                attempt_armed   = 1'b0;
                last_attempt_ms = '0;
            end
        end
        res.alarm_active  = (shown_reason != hosl_pkg::REASON_NONE);
        res.alarm_reason  = shown_reason;
        res.alarm_latched = (held_reason != hosl_pkg::REASON_NONE);
        return res;
    endfunction

    function automatic hosl_pkg::t_item calm_item(logic [TIME_W-1:0] stamp);
        hosl_pkg::t_item it;
        it                      = '0;
        it.req_type             = hosl_pkg::REQ_MONITOR;
        it.now_ms               = stamp;
        it.link_up              = 1'b1;
        it.heater_reading_valid = 1'b1;
        it.temperature          = 16'sd700;
        it.plug_watts_ok        = 1'b1;
        it.plug_relay_on        = 1'b1;
        return it;
    endfunction

    function automatic logic [15:0] near_u16(int center, int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span + center;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic logic [15:0] near_s16(int center, int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span + center;
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v[15:0];
    endfunction

    // mode: 0 calm, 1 overheating, 2 plug left drawing
    function automatic hosl_pkg::t_item random_item(logic [TIME_W-1:0] stamp, int mode);
        hosl_pkg::t_item it;
        int              thr, tmax;
        thr  = int'(active_cfg.watts_threshold);
        tmax = int'($signed(active_cfg.temp_max));
        it.req_type             = ($urandom_range(0, 39) == 0) ? hosl_pkg::REQ_GRACE
                                                               : hosl_pkg::REQ_MONITOR;
        it.now_ms               = stamp;
        it.maintenance_busy     = ($urandom_range(0, 29) == 0);
        it.calibration_active   = ($urandom_range(0, 9) == 0);
        it.link_up              = ($urandom_range(0, 7) != 0);
        it.heater_off           = (mode == 2) ? ($urandom_range(0, 7) != 0)
                                              : 1'($urandom_range(0, 1));
        it.heater_reading_valid = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 7) == 0) begin
            it.temperature = 16'($urandom);
        end else begin
            it.temperature = (mode == 1) ? near_s16(tmax + 10, 20) : near_s16(tmax - 5, 30);
        end
        if ($urandom_range(0, 7) == 0) begin
            it.heater_watts = 16'($urandom);
        end else begin
            it.heater_watts = (mode == 1) ? near_u16(thr + 5, 10) : near_u16(thr, 8);
        end
        it.plug_watts_ok = ($urandom_range(0, 5) != 0);
        if ($urandom_range(0, 7) == 0) begin
            it.plug_watts = 16'($urandom);
        end else begin
            it.plug_watts = (mode == 2) ? near_u16(thr + 5, 10) : near_u16(thr, 8);
        end
        it.plug_relay_on = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    task automatic report_mismatch(string field, logic [1:0] got, logic [1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        end
    endtask

    task automatic send_item(hosl_pkg::t_item it);
        in_valid <= 1'b1;
        drv_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_alarms.push_back(predict_alarm(it));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_alarms.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(hosl_pkg::t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            hosl_pkg::CFG_OVERRIDE_EN:  active_cfg.overtemp_alarm_en     = data[0];
            hosl_pkg::CFG_POWER_MON_EN: active_cfg.power_monitor_enabled = data[0];
            hosl_pkg::CFG_TEMP_MAX:     active_cfg.temp_max              = data[15:0];
            hosl_pkg::CFG_WATTS_THR:    active_cfg.watts_threshold       = data[15:0];
            hosl_pkg::CFG_PLUG_CFG:     active_cfg.plug_configured       = data[0];
            hosl_pkg::CFG_GRACE_MS:     active_cfg.grace_ms              = data;
            hosl_pkg::CFG_RETRY_MS:     active_cfg.retry_ms              = data;
            default: ;
        endcase
    endtask

    task automatic test_temperature_alarm();
        hosl_pkg::t_item it;
        send_item(calm_item(48'd1000));
        it = calm_item(48'd2000);
        it.temperature  = 16'sd821;
        it.heater_watts = 16'd6;
        send_item(it);
        it = calm_item(48'd3000);
        it.temperature  = 16'sd820;
        it.heater_watts = 16'd6;
        send_item(it);
        it = calm_item(48'd4000);
        it.temperature  = 16'sh7FFF;
        it.heater_watts = 16'hFFFF;
        send_item(it);
        it.now_ms = 48'd5000;
        send_item(it);
        it.now_ms = 48'd34000;
        send_item(it);
        it = calm_item(48'd36000);
        it.temperature  = 16'sh7FFF;
        it.heater_watts = 16'd5;
        send_item(it);
        it = calm_item(48'd37000);
        it.temperature  = 16'sh8000;
        it.heater_watts = 16'hFFFF;
        send_item(it);
        it = calm_item(48'd38000);
        it.temperature          = 16'sd900;
        it.heater_watts         = 16'd100;
        it.heater_reading_valid = 1'b0;
        send_item(it);
    endtask

    task automatic test_plug_alarm();
        hosl_pkg::t_item it;
        wait_drain();
        write_reg(hosl_pkg::CFG_PLUG_CFG, 22'd1);
        it = calm_item(48'd100000);
        it.heater_off = 1'b1;
        it.plug_watts = 16'hFFFF;
        send_item(it);
        it.now_ms  = 48'd101000;
        it.link_up = 1'b0;
        send_item(it);
        it.now_ms             = 48'd102000;
        it.link_up            = 1'b1;
        it.calibration_active = 1'b1;
        send_item(it);
        it.now_ms             = 48'd103000;
        it.calibration_active = 1'b0;
        it.plug_watts_ok      = 1'b0;
        send_item(it);
        it.now_ms        = 48'd104000;
        it.plug_watts_ok = 1'b1;
        it.plug_watts    = 16'd6;
        send_item(it);
        it = calm_item(48'd105000);
        it.temperature        = 16'sd900;
        it.heater_watts       = 16'd100;
        it.calibration_active = 1'b1;
        send_item(it);
        it.now_ms             = 48'd106000;
        it.calibration_active = 1'b0;
        it.link_up            = 1'b0;
        send_item(it);
    endtask

    task automatic test_grace_and_maintenance();
        hosl_pkg::t_item it;
        it = calm_item(48'd200000);
        it.req_type         = hosl_pkg::REQ_GRACE;
        it.maintenance_busy = 1'b1;
        send_item(it);
        it = calm_item(48'd250000);
        it.heater_off = 1'b1;
        it.plug_watts = 16'd500;
        send_item(it);
        it.now_ms           = 48'd260000;
        it.maintenance_busy = 1'b1;
        send_item(it);
        it.now_ms           = 48'd300000;
        it.maintenance_busy = 1'b0;
        send_item(it);
    endtask

    task automatic test_time_wrap();
        hosl_pkg::t_item it;
        it = calm_item(48'hFFFF_FFFF_0000);
        it.req_type = hosl_pkg::REQ_GRACE;
        send_item(it);
        it = calm_item(48'hFFFF_FFFF_FFFF);
        it.temperature  = 16'sd900;
        it.heater_watts = 16'd100;
        send_item(it);
        it.now_ms = 48'd5;
        send_item(it);
        it.now_ms = 48'd1000000;
        send_item(it);
        it.now_ms = 48'd500;
        send_item(it);
    endtask

    task automatic test_random_phases();
        hosl_pkg::t_cfg    c;
        logic [TIME_W-1:0] clock_ms;
        int                phase, n, span, burst_left, mode;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            c.overtemp_alarm_en     = ($urandom_range(0, 3) != 0);
            c.power_monitor_enabled = ($urandom_range(0, 3) != 0);
            c.temp_max              = 16'(int'($urandom_range(0, 1700)) - 200);
            c.watts_threshold       = 16'($urandom_range(0, 200));
            c.plug_configured       = ($urandom_range(0, 3) != 0);
            c.grace_ms              = 22'($urandom_range(0, 20000));
            c.retry_ms              = 22'($urandom_range(0, 10000));
            if (phase == 0) begin
                c.overtemp_alarm_en     = 1'b1;
                c.power_monitor_enabled = 1'b1;
                c.temp_max              = 16'sh8000;
                c.watts_threshold       = 16'd0;
                c.plug_configured       = 1'b1;
                c.grace_ms              = 22'd0;
                c.retry_ms              = 22'd0;
            end else if (phase == 1) begin
                c.overtemp_alarm_en     = 1'b0;
                c.power_monitor_enabled = 1'b0;
                c.temp_max              = 16'sh7FFF;
                c.watts_threshold       = 16'hFFFF;
                c.grace_ms              = 22'(MAX_MS);
                c.retry_ms              = 22'(MAX_MS);
            end else if (phase == 2) begin
                c.plug_configured = 1'b0;
            end
            wait_drain();
            write_reg(hosl_pkg::CFG_OVERRIDE_EN,  {21'd0, c.overtemp_alarm_en});
            write_reg(hosl_pkg::CFG_POWER_MON_EN, {21'd0, c.power_monitor_enabled});
            write_reg(hosl_pkg::CFG_TEMP_MAX,     {6'd0, c.temp_max});
            write_reg(hosl_pkg::CFG_WATTS_THR,    {6'd0, c.watts_threshold});
            write_reg(hosl_pkg::CFG_PLUG_CFG,     {21'd0, c.plug_configured});
            write_reg(hosl_pkg::CFG_GRACE_MS,     c.grace_ms);
            write_reg(hosl_pkg::CFG_RETRY_MS,     c.retry_ms);

            span       = int'(c.retry_ms) / 4 + int'(c.grace_ms) / 8 + 50;
            clock_ms   = {16'($urandom), $urandom};
            burst_left = 0;
            mode       = 0;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0) begin
                        in_valid <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge clk);
                    end
                end
                burst_left--;
                if ($urandom_range(0, 7) == 0) mode = $urandom_range(0, 2);
                case ($urandom_range(0, 19))
                    0:       clock_ms = clock_ms - $urandom_range(0, 4 * span);
                    1:       clock_ms = clock_ms + $urandom;
                    default: clock_ms = clock_ms + $urandom_range(0, span);
                endcase
                send_item(random_item(clock_ms, mode));
            end
        end
    endtask

    // receiver: switch between never, light, heavy and periodic stalls
    always @(posedge clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_tick[2];
        endcase
    end

    always @(posedge clk) begin
        hosl_pkg::t_result want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (expected_alarms.size() == 0) begin
                report_mismatch("unexpected transaction", alarm_reason, 2'd0);
            end else begin
                want = expected_alarms.pop_front();
                if (alarm_active !== want.alarm_active)
                    report_mismatch("alarm_active", {1'b0, alarm_active}, {1'b0, want.alarm_active});
                if (alarm_reason !== want.alarm_reason)
                    report_mismatch("alarm_reason", alarm_reason, want.alarm_reason);
                if (alarm_latched !== want.alarm_latched)
                    report_mismatch("alarm_latched", {1'b0, alarm_latched},
                                    {1'b0, want.alarm_latched});
                if (plug_off_command !== want.plug_off_command)
                    report_mismatch("plug_off_command", {1'b0, plug_off_command},
                                    {1'b0, want.plug_off_command});
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= hosl_pkg::CFG_OVERRIDE_EN;
        cfg_data <= '0;
        in_valid <= 1'b0;
        drv_item <= '0;
        active_cfg.overtemp_alarm_en     = hosl_pkg::RST_OVERRIDE_EN;
        active_cfg.power_monitor_enabled = hosl_pkg::RST_POWER_MON_EN;
        active_cfg.temp_max              = hosl_pkg::RST_TEMP_MAX;
        active_cfg.watts_threshold       = hosl_pkg::RST_WATTS_THR;
        active_cfg.plug_configured       = hosl_pkg::RST_PLUG_CFG;
        active_cfg.grace_ms              = hosl_pkg::RST_GRACE_MS;
        active_cfg.retry_ms              = hosl_pkg::RST_RETRY_MS;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_temperature_alarm();
        test_plug_alarm();
        test_grace_and_maintenance();
        test_time_wrap();
        test_random_phases();
        wait_drain();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- heater_overtemp_safety_latch_unit.f -----
rtl/core/hosl_pkg.sv
rtl/core/hosl_core.sv
rtl/core/heater_overtemp_safety_latch_unit.sv
dv/heater_overtemp_safety_latch_unit_tb.sv
